FILE: src/zhts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package zhts_pkg;

  // default sizes
  localparam int ZHTS_MAX_ZONES   = 16;
  localparam int ZHTS_COORD_WIDTH = 16;
  localparam int ZHTS_NEAR_LIMIT  = 75;
  localparam int ZHTS_ID_W        = 4;

  // operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_RADIUS = 2'd0;
  localparam logic [1:0] CFG_ALG    = 2'd1;
  localparam logic [1:0] CFG_COUNT  = 2'd2;

  // selection algorithms
  localparam logic [1:0] ALG_SMALLEST   = 2'd0;
  localparam logic [1:0] ALG_LARGEST    = 2'd1;
  localparam logic [1:0] ALG_POSITIONAL = 2'd2;
  localparam logic [1:0] ALG_CENTER     = 2'd3;

  // multiplier sequence steps
  localparam logic [2:0] MS_AREA = 3'd0;
  localparam logic [2:0] MS_CCX  = 3'd1;
  localparam logic [2:0] MS_CCY  = 3'd2;
  localparam logic [2:0] MS_CPX  = 3'd3;
  localparam logic [2:0] MS_CPY  = 3'd4;
  localparam logic [2:0] MS_DONE = 3'd5;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CAP_RD, ST_CAP_EV, ST_CAP_END, ST_NONE,
    ST_PA, ST_PA_W, ST_PB, ST_PB_EV, ST_EMIT,
    ST_POS, ST_POS_AC, ST_POS_EXT, ST_POS_MUL, ST_DIV, ST_DIV_FIX, ST_RANK,
    ST_SEL, ST_SEL_C, ST_SEL_M, ST_SEL_D, ST_PICK
  } state_t;

  typedef struct packed {
    logic wr;
    logic start;
    logic rd_j;
    logic i_clr;
    logic i_inc;
    logic j_load;
    logic j_inc;
    logic cap_eval;
    logic a_latch;
    logic pos_acc;
    logic pos_ext;
    logic pos_mul;
    logic div_step;
    logic div_fix;
    logic rank_inc;
    logic pick_rank;
    logic c_latch;
    logic m_clr;
    logic m_step;
    logic sel_take;
    logic push_none;
    logic push_cap;
    logic push_pick;
  } cmd_t;

  typedef struct packed {
    logic i_end;
    logic j_end;
    logic i_cap;
    logic j_cap;
    logic n_zero;
    logic n_one;
    logic strict_zero;
    logic ovl_hit;
    logic m_done;
    logic take_ok;
    logic div_done;
    logic rank_hit;
    logic rem_one;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: src/zhts_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module zhts_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_operation,
  output logic          in_ready,
  input  logic [1:0]    alg,
  input  zhts_pkg::sts_t sts,
  output zhts_pkg::cmd_t cmd
);
  import zhts_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_ready = (state_r == ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_valid && in_operation == OP_QUERY) state_nxt = ST_CAP_RD;
      ST_CAP_RD:  state_nxt = sts.i_end ? ST_CAP_END : ST_CAP_EV;
      ST_CAP_EV:  state_nxt = ST_CAP_RD;
      ST_CAP_END: begin
        if (sts.n_zero || (sts.n_one && sts.strict_zero)) state_nxt = ST_NONE;
        else if (sts.n_one)                                state_nxt = ST_EMIT;
        else                                               state_nxt = ST_PA;
      end
      ST_NONE:    if (sts.out_free) state_nxt = ST_IDLE;
      ST_PA: begin
        if (sts.i_end)      state_nxt = ST_EMIT;
        else if (sts.i_cap) state_nxt = ST_PA_W;
      end
      ST_PA_W:    state_nxt = ST_PB;
      ST_PB: begin
        if (sts.j_end)      state_nxt = ST_PA;
        else if (sts.j_cap) state_nxt = ST_PB_EV;
      end
      ST_PB_EV: begin
        if (sts.ovl_hit) state_nxt = (alg == ALG_POSITIONAL) ? ST_POS : ST_SEL;
        else             state_nxt = ST_PB;
      end
      ST_EMIT: begin
        if (sts.i_end) state_nxt = ST_IDLE;
        else if (sts.i_cap && sts.out_free && sts.rem_one) state_nxt = ST_IDLE;
      end
      ST_POS: begin
        if (sts.i_end)      state_nxt = ST_POS_EXT;
        else if (sts.i_cap) state_nxt = ST_POS_AC;
      end
      ST_POS_AC:  state_nxt = ST_POS;
      ST_POS_EXT: state_nxt = ST_POS_MUL;
      ST_POS_MUL: state_nxt = ST_DIV;
      ST_DIV:     if (sts.div_done) state_nxt = ST_DIV_FIX;
      ST_DIV_FIX: state_nxt = ST_RANK;
      ST_RANK: begin
        if (sts.i_end)                       state_nxt = ST_IDLE;
        else if (sts.i_cap && sts.rank_hit) state_nxt = ST_PICK;
      end
      ST_SEL: begin
        if (sts.i_end)      state_nxt = ST_PICK;
        else if (sts.i_cap) state_nxt = ST_SEL_C;
      end
      ST_SEL_C:   state_nxt = ST_SEL_M;
      ST_SEL_M:   if (sts.m_done) state_nxt = ST_SEL_D;
      ST_SEL_D:   state_nxt = ST_SEL;
      ST_PICK:    if (sts.out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.wr    = in_valid && in_operation == OP_LOAD;
        cmd.start = in_valid && in_operation == OP_QUERY;
      end
      ST_CAP_RD:  ;
      ST_CAP_EV: begin
        cmd.cap_eval = 1'b1;
        cmd.i_inc    = 1'b1;
      end
      ST_CAP_END: cmd.i_clr = 1'b1;
      ST_NONE:    cmd.push_none = sts.out_free;
      ST_PA: begin
        if (sts.i_end)       cmd.i_clr = 1'b1;
        else if (!sts.i_cap) cmd.i_inc = 1'b1;
      end
      ST_PA_W: begin
        cmd.a_latch = 1'b1;
        cmd.j_load  = 1'b1;
      end
      ST_PB: begin
        cmd.rd_j = 1'b1;
        if (sts.j_end)       cmd.i_inc = 1'b1;
        else if (!sts.j_cap) cmd.j_inc = 1'b1;
      end
      ST_PB_EV: begin
        if (sts.ovl_hit) cmd.i_clr = 1'b1;
        else             cmd.j_inc = 1'b1;
      end
      ST_EMIT: begin
        if (!sts.i_end) begin
          if (!sts.i_cap) cmd.i_inc = 1'b1;
          else if (sts.out_free) begin
            cmd.push_cap = 1'b1;
            cmd.i_inc    = 1'b1;
          end
        end
      end
      ST_POS:     if (!sts.i_end && !sts.i_cap) cmd.i_inc = 1'b1;
      ST_POS_AC: begin
        cmd.pos_acc = 1'b1;
        cmd.i_inc   = 1'b1;
      end
      ST_POS_EXT: cmd.pos_ext = 1'b1;
      ST_POS_MUL: cmd.pos_mul = 1'b1;
      ST_DIV:     cmd.div_step = !sts.div_done;
      ST_DIV_FIX: begin
        cmd.div_fix = 1'b1;
        cmd.i_clr   = 1'b1;
      end
      ST_RANK: begin
        if (!sts.i_end) begin
          if (!sts.i_cap) cmd.i_inc = 1'b1;
          else if (sts.rank_hit) cmd.pick_rank = 1'b1;
          else begin
            cmd.rank_inc = 1'b1;
            cmd.i_inc    = 1'b1;
          end
        end
      end
      ST_SEL:     if (!sts.i_end && !sts.i_cap) cmd.i_inc = 1'b1;
      ST_SEL_C: begin
        cmd.c_latch = 1'b1;
        cmd.m_clr   = 1'b1;
      end
      // the step taken on the done count folds in the last square
      ST_SEL_M:   cmd.m_step = 1'b1;
      ST_SEL_D: begin
        cmd.sel_take = sts.take_ok;
        cmd.i_inc    = 1'b1;
      end
      ST_PICK:    cmd.push_pick = sts.out_free;
      default:    ;
    endcase
  end

  // checks
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_operation == OP_QUERY) |=> (state_r == ST_CAP_RD))
    else $error("query not started");
  a_one_push: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.push_none, cmd.push_cap, cmd.push_pick}) <= 1)
    else $error("two result pushes at once");
  a_div_fix: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_FIX) |-> $past(state_r == ST_DIV))
    else $error("divider skipped");

endmodule
`default_nettype wire

FILE: src/zhts_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module zhts_dp #(
  parameter int MAX_ZONES   = zhts_pkg::ZHTS_MAX_ZONES,
  parameter int COORD_WIDTH = zhts_pkg::ZHTS_COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  zhts_pkg::cmd_t                cmd,
  output zhts_pkg::sts_t                sts,
  input  logic [7:0]                    radius,
  input  logic [1:0]                    alg,
  input  logic [4:0]                    zone_count,
  input  logic [3:0]                    wr_id,
  input  logic signed [COORD_WIDTH-1:0] wr_left,
  input  logic signed [COORD_WIDTH-1:0] wr_top,
  input  logic signed [COORD_WIDTH-1:0] wr_right,
  input  logic signed [COORD_WIDTH-1:0] wr_bottom,
  input  logic signed [COORD_WIDTH-1:0] qx,
  input  logic signed [COORD_WIDTH-1:0] qy,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [zhts_pkg::ZHTS_ID_W-1:0] out_hit_zone,
  output logic                          out_none_found,
  output logic                          out_last
);
  import zhts_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int XW   = CW + 3;
  localparam int AW   = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
  localparam int IW   = $clog2(MAX_ZONES + 1);
  localparam int NUMW = XW - 1 + IW;
  localparam int DCW  = $clog2(NUMW + 1);
  localparam int PW   = 2 * CW;
  localparam int EW   = 4 * CW;

  // truncating half of a sum
  function automatic logic signed [CW-1:0] center(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
    logic signed [CW:0] s;
    begin
      s = (CW+1)'(a) + (CW+1)'(b);
      s = s + $signed((CW+1)'(s[CW]));
      center = CW'(s >>> 1);
    end
  endfunction

  function automatic logic [CW-1:0] absdiff(input logic signed [CW-1:0] a,
                                            input logic signed [CW-1:0] b);
    logic signed [CW:0] d;
    begin
      d = (CW+1)'(a) - (CW+1)'(b);
      absdiff = d[CW] ? CW'(-d) : CW'(d);
    end
  endfunction

  function automatic logic [CW-1:0] extent(input logic signed [CW-1:0] lo,
                                           input logic signed [CW-1:0] hi);
    logic signed [CW:0] d;
    begin
      d = (CW+1)'(hi) - (CW+1)'(lo);
      extent = d[CW] ? '0 : d[CW-1:0];
    end
  endfunction

  // zone memory
  logic [EW-1:0] mem [MAX_ZONES];
  logic [EW-1:0] rd_r;
  logic [IW-1:0] i_r, j_r, n_r, rem_r, rank_r, idx_r, cnt;
  logic [AW-1:0] rd_addr;

  assign rd_addr = cmd.rd_j ? j_r[AW-1:0] : i_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.wr && ({3'b000, wr_id} < 7'(MAX_ZONES)))
      mem[AW'(wr_id)] <= {wr_left, wr_top, wr_right, wr_bottom};
    rd_r <= mem[rd_addr];
  end

  logic signed [CW-1:0] z_l, z_t, z_r, z_b, a_l, a_t, a_r, a_b;
  logic signed [XW-1:0] zl, zt, zr, zb, al, at, ar, ab, radx, halfx, pxx, pyx;
  logic signed [CW-1:0] px_r, py_r;

  assign {z_l, z_t, z_r, z_b} = rd_r;
  assign zl = XW'(z_l);
  assign zt = XW'(z_t);
  assign zr = XW'(z_r);
  assign zb = XW'(z_b);
  assign radx  = $signed({{(XW-8){1'b0}}, radius});
  assign halfx = radx >>> 1;
  assign pxx = XW'(px_r);
  assign pyx = XW'(py_r);

  assign cnt = ({2'b00, zone_count} > 7'(MAX_ZONES)) ? IW'(MAX_ZONES) : IW'(zone_count);

  // capture and scan counters
  logic [MAX_ZONES-1:0] cap_r;
  logic strict_r;
  logic cap_hit, strict_hit;

  assign cap_hit = (zl - radx <= pxx) && (pxx <= zr + radx) &&
                   (zt - radx <= pyx) && (pyx <= zb + radx);
  assign strict_hit = (zl <= pxx) && (pxx < zr) && (zt <= pyx) && (pyx < zb);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r <= '0; j_r <= '0; n_r <= '0; rem_r <= '0; rank_r <= '0;
      cap_r <= '0; strict_r <= 1'b0;
    end else begin
      if (cmd.start) begin
        px_r <= qx;
        py_r <= qy;
        cap_r <= '0; n_r <= '0; rem_r <= '0; rank_r <= '0;
        strict_r <= 1'b0;
      end
      if (cmd.start || cmd.i_clr) i_r <= '0;
      else if (cmd.i_inc)         i_r <= i_r + 1'b1;
      if (cmd.j_load)     j_r <= i_r + 1'b1;
      else if (cmd.j_inc) j_r <= j_r + 1'b1;
      if (cmd.cap_eval) begin
        cap_r[i_r[AW-1:0]] <= cap_hit;
        if (cap_hit) begin
          n_r   <= n_r + 1'b1;
          rem_r <= rem_r + 1'b1;
        end
        if (strict_hit) strict_r <= 1'b1;
      end
      if (cmd.push_cap) rem_r <= rem_r - 1'b1;
      if (cmd.rank_inc) rank_r <= rank_r + 1'b1;
    end
  end

  // pair overlap against the held zone
  logic [EW-1:0] ahold_r;
  always_ff @(posedge clk) if (cmd.a_latch) ahold_r <= rd_r;
  assign {a_l, a_t, a_r, a_b} = ahold_r;
  assign al = XW'(a_l);
  assign at = XW'(a_t);
  assign ar = XW'(a_r);
  assign ab = XW'(a_b);

  logic ovl_hit;
  assign ovl_hit = (((at > zt) ? at : zt) + radx < ((ab < zb) ? ab : zb)) &&
                   (((al > zl) ? al : zl) + radx < ((ar < zr) ? ar : zr));

  // positional split: intersection, scaled offset, restoring divide
  logic signed [XW-1:0] pl_r, pt_r, pr_r, pb_r, diff_r;
  logic signed [XW-1:0] ct, cl, cb, cr, pw, ph, pwc, phc;
  logic [XW-2:0] ext_r;
  logic [NUMW-1:0] dvd_r;
  logic [XW-1:0] drem_r, dsh;
  logic [DCW-1:0] dcnt_r;
  logic neg_r, pos_first_r, vert;

  assign ct = zt - halfx;
  assign cl = zl - halfx;
  assign cb = zb + halfx;
  assign cr = zr + halfx;
  assign pw = pr_r - pl_r;
  assign ph = pb_r - pt_r;
  assign pwc = (pw < XW'(1)) ? XW'(1) : pw;
  assign phc = (ph < XW'(1)) ? XW'(1) : ph;
  assign vert = phc > pwc;
  assign dsh = {drem_r[XW-2:0], dvd_r[NUMW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_first_r <= 1'b1;
      dcnt_r <= '0;
    end else begin
      if (cmd.start) pos_first_r <= 1'b1;
      if (cmd.pos_acc) begin
        pos_first_r <= 1'b0;
        pt_r <= (pos_first_r || ct > pt_r) ? ct : pt_r;
        pl_r <= (pos_first_r || cl > pl_r) ? cl : pl_r;
        pb_r <= (pos_first_r || cb < pb_r) ? cb : pb_r;
        pr_r <= (pos_first_r || cr < pr_r) ? cr : pr_r;
      end
      if (cmd.pos_ext) begin
        ext_r  <= vert ? phc[XW-2:0] : pwc[XW-2:0];
        diff_r <= vert ? (pyx - pt_r) : (pxx - pl_r);
      end
      if (cmd.pos_mul) begin
        neg_r  <= diff_r[XW-1];
        dvd_r  <= NUMW'(diff_r[XW-2:0]) * NUMW'(n_r);
        drem_r <= '0;
        dcnt_r <= '0;
      end
      if (cmd.div_step) begin
        if (dsh >= {1'b0, ext_r}) begin
          drem_r <= dsh - {1'b0, ext_r};
          dvd_r  <= {dvd_r[NUMW-2:0], 1'b1};
        end else begin
          drem_r <= dsh;
          dvd_r  <= {dvd_r[NUMW-2:0], 1'b0};
        end
        dcnt_r <= dcnt_r + 1'b1;
      end
      if (cmd.div_fix) begin
        if (neg_r)                       idx_r <= '0;
        else if (dvd_r >= NUMW'(n_r))    idx_r <= n_r - 1'b1;
        else                             idx_r <= IW'(dvd_r);
      end
    end
  end

  // area and centre selection over one shared multiplier
  logic signed [CW-1:0] c_cx_r, c_cy_r, s_cx_r, s_cy_r;
  logic [CW-1:0] c_w_r, c_h_r, mul_a, mul_b;
  logic [PW-1:0] prod_r, area_c_r, area_s_r;
  logic [PW:0] cc_r, dc_r, ds_r;
  logic [2:0] mstep_r, mprev;
  logic sel_first_r, better;
  logic [ZHTS_ID_W-1:0] pick_r;

  assign mprev = mstep_r - 3'd1;

  always_comb begin
    mul_a = c_w_r;
    mul_b = c_h_r;
    unique case (mstep_r)
      MS_CCX: begin
        mul_a = absdiff(c_cx_r, s_cx_r);
        mul_b = mul_a;
      end
      MS_CCY: begin
        mul_a = absdiff(c_cy_r, s_cy_r);
        mul_b = mul_a;
      end
      MS_CPX: begin
        mul_a = absdiff(c_cx_r, px_r);
        mul_b = mul_a;
      end
      MS_CPY: begin
        mul_a = absdiff(c_cy_r, py_r);
        mul_b = mul_a;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mstep_r <= '0;
      sel_first_r <= 1'b1;
    end else begin
      if (cmd.start) sel_first_r <= 1'b1;
      if (cmd.c_latch) begin
        c_cx_r <= center(z_l, z_r);
        c_cy_r <= center(z_t, z_b);
        c_w_r  <= extent(z_l, z_r);
        c_h_r  <= extent(z_t, z_b);
      end
      if (cmd.m_clr) mstep_r <= MS_AREA;
      if (cmd.m_step) begin
        mstep_r <= mstep_r + 3'd1;
        if (mstep_r != MS_DONE) prod_r <= mul_a * mul_b;
        if (mstep_r != MS_AREA) begin
          unique case (mprev)
            MS_AREA: area_c_r <= prod_r;
            MS_CCX:  cc_r <= (PW+1)'(prod_r);
            MS_CCY:  cc_r <= cc_r + (PW+1)'(prod_r);
            MS_CPX:  dc_r <= (PW+1)'(prod_r);
            MS_CPY:  dc_r <= dc_r + (PW+1)'(prod_r);
            default: ;
          endcase
        end
      end
      if (cmd.sel_take) begin
        sel_first_r <= 1'b0;
        s_cx_r <= c_cx_r;
        s_cy_r <= c_cy_r;
        area_s_r <= area_c_r;
        ds_r <= dc_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sel_take)  pick_r <= ZHTS_ID_W'(i_r);
    if (cmd.pick_rank) pick_r <= ZHTS_ID_W'(i_r);
  end

  always_comb begin
    unique case (alg)
      ALG_SMALLEST: better = area_c_r < area_s_r;
      ALG_LARGEST:  better = area_c_r > area_s_r;
      ALG_CENTER:   better = (cc_r > (PW+1)'(ZHTS_NEAR_LIMIT)) ? (dc_r < ds_r)
                                                              : (area_c_r < area_s_r);
      default:      better = 1'b0;
    endcase
  end

  // result word register
  logic out_valid_r, out_none_r, out_last_r;
  logic [ZHTS_ID_W-1:0] out_id_r;
  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push_none || cmd.push_cap || cmd.push_pick) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_none) begin
      out_id_r <= '0; out_none_r <= 1'b1; out_last_r <= 1'b1;
    end else if (cmd.push_cap) begin
      out_id_r <= ZHTS_ID_W'(i_r); out_none_r <= 1'b0; out_last_r <= (rem_r == IW'(1));
    end else if (cmd.push_pick) begin
      out_id_r <= pick_r; out_none_r <= 1'b0; out_last_r <= 1'b1;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit_zone   = out_id_r;
  assign out_none_found = out_none_r;
  assign out_last       = out_last_r;

  // status
  always_comb begin
    sts.i_end       = (i_r == cnt);
    sts.j_end       = (j_r == cnt);
    sts.i_cap       = (i_r != cnt) && cap_r[i_r[AW-1:0]];
    sts.j_cap       = (j_r != cnt) && cap_r[j_r[AW-1:0]];
    sts.n_zero      = (n_r == '0);
    sts.n_one       = (n_r == IW'(1));
    sts.strict_zero = !strict_r;
    sts.ovl_hit     = ovl_hit;
    sts.m_done      = (mstep_r == MS_DONE);
    sts.take_ok     = sel_first_r || better;
    sts.div_done    = (dcnt_r == DCW'(NUMW));
    sts.rank_hit    = (rank_r == idx_r);
    sts.rem_one     = (rem_r == IW'(1));
    sts.out_free    = out_free;
  end

  // checks
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push_none || cmd.push_cap || cmd.push_pick) |-> out_free)
    else $error("result word overwritten");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= n_r)
    else $error("remaining count above captured count");
  a_push_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_cap |-> sts.i_cap)
    else $error("emitting uncaptured zone");
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> !sts.div_done)
    else $error("divider stepped past end");

endmodule
`default_nettype wire

FILE: src/zone_hit_test_select.sv
`timescale 1ns / 1ps
`default_nettype none
// Zone table with point hit test. A load word writes one rectangle. A
// query walks the table through its single read port: a capture pass over
// the zones in use, then, when more than one zone is captured, a scan of
// the captured pairs for overlap, then either an emit pass over the table
// that sends the captured list (stalling on the output), or a selection
// pass over the captured zones on the shared multiplier, or for the
// positional split a pass over the captured zones plus a restoring divider
// of COORD_WIDTH+2+clog2(MAX_ZONES+1) steps. Input is taken only while no
// query is running, but a result word waiting in the output register does
// not block it.
// The table is not cleared at reset; querying an entry never loaded is
// undefined.
module zone_hit_test_select #(
  parameter int MAX_ZONES   = zhts_pkg::ZHTS_MAX_ZONES,
  parameter int COORD_WIDTH = zhts_pkg::ZHTS_COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [7:0]                    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_operation,
  input  logic [3:0]                    in_zone_id,
  input  logic signed [COORD_WIDTH-1:0] in_rect_left,
  input  logic signed [COORD_WIDTH-1:0] in_rect_top,
  input  logic signed [COORD_WIDTH-1:0] in_rect_right,
  input  logic signed [COORD_WIDTH-1:0] in_rect_bottom,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [3:0]                    out_hit_zone,
  output logic                          out_none_found,
  output logic                          out_last
);
  import zhts_pkg::*;

  // configuration registers
  logic [7:0] radius_r;
  logic [1:0] alg_r;
  logic [4:0] count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 8'd20;
      alg_r    <= ALG_SMALLEST;
      count_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RADIUS: radius_r <= cfg_data;
        CFG_ALG:    alg_r    <= cfg_data[1:0];
        CFG_COUNT:  count_r  <= cfg_data[4:0];
        default:    ;
      endcase
    end
  end

  cmd_t cmd;
  sts_t sts;

  zhts_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_ready     (in_ready),
    .alg          (alg_r),
    .sts          (sts),
    .cmd          (cmd)
  );

  zhts_dp #(
    .MAX_ZONES   (MAX_ZONES),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .radius         (radius_r),
    .alg            (alg_r),
    .zone_count     (count_r),
    .wr_id          (in_zone_id),
    .wr_left        (in_rect_left),
    .wr_top         (in_rect_top),
    .wr_right       (in_rect_right),
    .wr_bottom      (in_rect_bottom),
    .qx             (in_point_x),
    .qy             (in_point_y),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_hit_zone   (out_hit_zone),
    .out_none_found (out_none_found),
    .out_last       (out_last)
  );

endmodule
`default_nettype wire

FILE: dv/tb_zone_hit_test_select.sv
`timescale 1ns / 1ps
module tb_zone_hit_test_select;
  import zhts_pkg::*;

  typedef struct {
    longint l, t, r, b;
  } rect_s;

  typedef struct packed {
    logic [3:0] hit;
    logic       none;
    logic       last;
  } answer_s;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = CFG_RADIUS;
  logic [7:0]         cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_operation = OP_LOAD;
  logic [3:0]         in_zone_id = '0;
  logic signed [15:0] in_rect_left = '0;
  logic signed [15:0] in_rect_top = '0;
  logic signed [15:0] in_rect_right = '0;
  logic signed [15:0] in_rect_bottom = '0;
  logic signed [15:0] in_point_x = '0;
  logic signed [15:0] in_point_y = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [3:0]         out_hit_zone;
  logic               out_none_found;
  logic               out_last;

  // mirror of the block state
  rect_s      zones[16];
  logic [7:0] radius_q = 8'd20;
  logic [1:0] alg_q = ALG_SMALLEST;
  logic [4:0] count_q = '0;
  answer_s    answers[$];
  int         fails = 0;
  bit         calm = 0;
  int         sink_stall = 0;

  zone_hit_test_select dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_operation(in_operation),
    .in_zone_id(in_zone_id), .in_rect_left(in_rect_left), .in_rect_top(in_rect_top),
    .in_rect_right(in_rect_right), .in_rect_bottom(in_rect_bottom),
    .in_point_x(in_point_x), .in_point_y(in_point_y),
    .out_valid(out_valid), .out_ready(out_ready), .out_hit_zone(out_hit_zone),
    .out_none_found(out_none_found), .out_last(out_last)
  );

  always #6 clk = ~clk;

  initial begin
    #50ms;
    $display("tb: failure");
    $finish;
  end

  // --- hit-test prediction ---
  function automatic void add_answer(answer_s w);
    answers.insert(answers.size(), w);
  endfunction

  function automatic longint zone_area(rect_s z);
    longint w, h;
    w = (z.r - z.l) < 0 ? 0 : z.r - z.l;
    h = (z.b - z.t) < 0 ? 0 : z.b - z.t;
    return w * h;
  endfunction

  function automatic longint sq(longint d);
    return d * d;
  endfunction

  function automatic longint lmax(longint a, longint b);
    return a > b ? a : b;
  endfunction

  function automatic longint lmin(longint a, longint b);
    return a < b ? a : b;
  endfunction

  function automatic bit centre_wins(rect_s a, rect_s b, longint px, longint py);
    longint ax, ay, bx, by;
    ax = (a.l + a.r) / 2; ay = (a.t + a.b) / 2;
    bx = (b.l + b.r) / 2; by = (b.t + b.b) / 2;
    if (sq(ax - bx) + sq(ay - by) > ZHTS_NEAR_LIMIT)
      return sq(ax - px) + sq(ay - py) < sq(bx - px) + sq(by - py);
    return zone_area(a) < zone_area(b);
  endfunction

  function automatic int split_pick(int cap[16], int n, longint px, longint py);
    longint half, t, l, b, r, w, h, idx;
    rect_s z;
    half = radius_q / 2;
    for (int i = 0; i < n; i++) begin
      z = zones[cap[i]];
      if (i == 0) begin
        t = z.t - half; l = z.l - half; b = z.b + half; r = z.r + half;
      end else begin
        t = lmax(t, z.t - half); l = lmax(l, z.l - half);
        b = lmin(b, z.b + half); r = lmin(r, z.r + half);
      end
    end
    w = lmax(r - l, 1);
    h = lmax(b - t, 1);
    if (h > w) idx = (py - t) * n / h;
    else idx = (px - l) * n / w;
    if (idx < 0) idx = 0;
    if (idx > n - 1) idx = n - 1;
    return cap[idx];
  endfunction

  function automatic void predict_hits(longint px, longint py);
    int     cap[16];
    int     n, strict, cnt, pick;
    longint rad;
    bit     ovl, better;
    rect_s  a, b;
    n = 0; strict = 0; ovl = 0;
    rad = radius_q;
    cnt = count_q > 16 ? 16 : count_q;
    for (int i = 0; i < cnt; i++) begin
      a = zones[i];
      if (a.l - rad <= px && px <= a.r + rad && a.t - rad <= py && py <= a.b + rad) begin
        cap[n] = i;
        n++;
      end
      if (a.l <= px && px < a.r && a.t <= py && py < a.b) strict++;
    end
    if (n == 0 || (n == 1 && strict == 0)) begin
      add_answer('{4'd0, 1'b1, 1'b1});
      return;
    end
    // any pair overlapping by more than the radius forces a selection
    for (int i = 0; i < n; i++)
      for (int j = i + 1; j < n; j++) begin
        a = zones[cap[i]]; b = zones[cap[j]];
        if (lmax(a.t, b.t) + rad < lmin(a.b, b.b) && lmax(a.l, b.l) + rad < lmin(a.r, b.r))
          ovl = 1;
      end
    if (!ovl) begin
      for (int i = 0; i < n; i++)
        add_answer('{cap[i][3:0], 1'b0, i == n - 1});
      return;
    end
    if (alg_q == ALG_POSITIONAL) begin
      pick = split_pick(cap, n, px, py);
      add_answer('{pick[3:0], 1'b0, 1'b1});
      return;
    end
    pick = 0;
    for (int i = 1; i < n; i++) begin
      a = zones[cap[i]]; b = zones[cap[pick]];
      case (alg_q)
        ALG_SMALLEST: better = zone_area(a) < zone_area(b);
        ALG_LARGEST: better = zone_area(a) > zone_area(b);
        default: better = centre_wins(a, b, px, py);
      endcase
      if (better) pick = i;
    end
    add_answer('{cap[pick][3:0], 1'b0, 1'b1});
  endfunction

  // --- result checking ---
  always @(posedge clk) begin
    answer_s exp_w;
    if (rst_n && out_valid && out_ready) begin
      if (answers.size() == 0) begin
        $error("unexpected result word hit_zone=%0d", out_hit_zone);
        fails++;
      end else begin
        exp_w = answers.pop_front();
        if (out_hit_zone !== exp_w.hit) begin
          $error("hit_zone expected %0d actual %0d", exp_w.hit, out_hit_zone);
          fails++;
        end
        if (out_none_found !== exp_w.none) begin
          $error("none_found expected %0d actual %0d", exp_w.none, out_none_found);
          fails++;
        end
        if (out_last !== exp_w.last) begin
          $error("last expected %0d actual %0d", exp_w.last, out_last);
          fails++;
        end
      end
    end
  end

  // result side back-pressure in bursts
  always @(posedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (sink_stall > 0) begin
      sink_stall--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      sink_stall = $urandom_range(0, 11);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // --- drivers ---
  function automatic longint clip16(longint v);
    return v < -32768 ? -32768 : (v > 32767 ? 32767 : v);
  endfunction

  task automatic send_word(logic op, logic [3:0] id, longint l, longint t, longint r,
                           longint b, longint px, longint py);
    in_valid <= 1'b1;
    in_operation <= op;
    in_zone_id <= id;
    in_rect_left <= l[15:0];
    in_rect_top <= t[15:0];
    in_rect_right <= r[15:0];
    in_rect_bottom <= b[15:0];
    in_point_x <= px[15:0];
    in_point_y <= py[15:0];
    do @(posedge clk); while (!in_ready);
    if (op == OP_LOAD) zones[id] = '{l, t, r, b};
    else predict_hits(px, py);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  function automatic longint rnd16();
    return longint'($signed(16'($urandom)));
  endfunction

  task automatic load_zone(logic [3:0] id, longint l, longint t, longint r, longint b);
    send_word(OP_LOAD, id, l, t, r, b, rnd16(), rnd16());
  endtask

  task automatic query_point(longint px, longint py);
    send_word(OP_QUERY, 4'($urandom), rnd16(), rnd16(), rnd16(), rnd16(), px, py);
  endtask

  // wait for every answer, then let a possible tail of work drain
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (answers.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_RADIUS: radius_q = val;
      CFG_ALG: alg_q = val[1:0];
      CFG_COUNT: count_q = val[4:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // --- tests ---
  task automatic test_directed();
    // reset values: empty table in use
    query_point(0, 0);
    load_zone(0, 0, 0, 100, 100);
    load_zone(1, 50, 50, 150, 150);
    load_zone(2, -32768, -32768, 32767, 32767);
    load_zone(3, 200, 0, 300, 100);
    drain();
    set_reg(CFG_COUNT, 8'd2);
    query_point(110, 110);     // overlapping pair, equal areas
    query_point(-10, -10);     // lone capture in the margin only
    query_point(10, 10);       // lone strict capture
    drain();
    set_reg(CFG_COUNT, 8'd4);
    for (int a = 0; a < 4; a++) begin
      drain();
      set_reg(CFG_ALG, 8'(a));
      query_point(75, 75);
      query_point(250, 50);
      query_point(32767, 32767);
      query_point(-32768, -32768);
    end
    drain();
    set_reg(CFG_RADIUS, 8'd0);
    query_point(100, 50);      // right edge excluded without margin
    query_point(0, 0);
    drain();
    set_reg(CFG_RADIUS, 8'd255);
    query_point(420, 0);
    for (int i = 4; i < 16; i++)
      load_zone(i[3:0], i * 30, i * 20, i * 30 + 90 - i * 9, i * 20 + 60);
    drain();
    set_reg(CFG_COUNT, 8'd31); // saturates at the table size
    query_point(300, 250);
    query_point(-32768, 32767);
  endtask

  task automatic test_random_phases();
    int     z, kind, span;
    longint l, t, w, h, rad;
    for (int ph = 0; ph < 9; ph++) begin
      drain();
      if (ph == 8) calm = 1;
      kind = $urandom_range(0, 3);
      set_reg(CFG_RADIUS, kind == 0 ? 8'd0 : (kind == 1 ? 8'd255 : 8'($urandom_range(0, 60))));
      set_reg(CFG_ALG, 8'(ph % 4));
      set_reg(CFG_COUNT, $urandom_range(0, 5) == 0 ? 8'($urandom_range(16, 31))
                                                   : 8'($urandom_range(1, 16)));
      for (int k = 0; k < 44; k++) begin
        if ($urandom_range(0, 9) < 3) begin
          if ($urandom_range(0, 4) == 0) begin
            load_zone(4'($urandom), rnd16(), rnd16(), rnd16(), rnd16());
          end else begin
            l = $urandom_range(0, 600) - 200;
            t = $urandom_range(0, 600) - 200;
            w = $urandom_range(0, 9) == 0 ? -longint'($urandom_range(0, 20))
                                          : $urandom_range(1, 300);
            h = $urandom_range(1, 300);
            load_zone(4'($urandom), l, t, l + w, t + h);
          end
        end else if ($urandom_range(0, 9) == 0) begin
          query_point(rnd16(), rnd16());
        end else begin
          // aim near a zone in use, margin included
          span = count_q > 16 ? 16 : count_q;
          z = $urandom_range(0, span - 1);
          rad = radius_q;
          w = lmax(zones[z].r - zones[z].l, 0) + 2 * rad + 2;
          h = lmax(zones[z].b - zones[z].t, 0) + 2 * rad + 2;
          query_point(clip16(zones[z].l - rad - 1 + longint'($urandom) % w),
                      clip16(zones[z].t - rad - 1 + longint'($urandom) % h));
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_phases();
    drain();
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: zone_hit_test_select.f
src/zhts_pkg.sv
src/zhts_ctrl.sv
src/zhts_dp.sv
src/zone_hit_test_select.sv
dv/tb_zone_hit_test_select.sv
